// File: sv/lisr_pkg.sv
// ----------------------------------------------------------------------------
// lisr_pkg
// Types, codes and fixed widths shared by the letterbox scaler files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package lisr_pkg;

    localparam int COORD_W     = 10;
    localparam int PIXEL_W     = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 11;
    localparam int LOGIC_W     = 11;
    localparam int QUEUE_DEPTH = 4;
    // reciprocal multiply: exact floor division for dividends below 2**LOGIC_W
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_W     = 15;

    typedef enum logic [0:0] {
        REQ_LOAD  = 1'b0,
        REQ_FETCH = 1'b1
    } req_type_t;

    typedef enum logic [1:0] {
        ROT_NONE = 2'd0,
        ROT_CW   = 2'd1,
        ROT_CCW  = 2'd2
    } rot_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROTATION = 3'd0,
        CFG_PANEL_W  = 3'd1,
        CFG_PANEL_H  = 3'd2,
        CFG_VIEW_W   = 3'd3,
        CFG_VIEW_H   = 3'd4,
        CFG_OFFSET_X = 3'd5,
        CFG_OFFSET_Y = 3'd6,
        CFG_SCALE    = 3'd7
    } cfg_idx_t;

    typedef struct packed {
        logic [1:0]  rotation;
        logic [10:0] panel_width;
        logic [10:0] panel_height;
        logic [8:0]  view_width;
        logic [8:0]  view_height;
        logic [9:0]  offset_x;
        logic [9:0]  offset_y;
        logic [2:0]  scale;
    } cfg_t;

    // one queued operation: a source write or a classified fetch
    typedef struct packed {
        logic               is_load;
        logic               geom_err;
        logic               bezel;
        logic [LOGIC_W-1:0] x;
        logic [LOGIC_W-1:0] y;
        logic [PIXEL_W-1:0] pixel;
    } q_entry_t;

    // ceil(2**RECIP_SHIFT / scale)
    function automatic logic [RECIP_W-1:0] recip_of(input logic [2:0] sc);
        logic [RECIP_W-1:0] r;
        unique case (sc)
            3'd2:    r = 15'd8192;
            3'd3:    r = 15'd5462;
            3'd4:    r = 15'd4096;
            3'd5:    r = 15'd3277;
            3'd6:    r = 15'd2731;
            3'd7:    r = 15'd2341;
            default: r = 15'd16384;
        endcase
        return r;
    endfunction

endpackage

// File: sv/lisr_ifs.sv
// ----------------------------------------------------------------------------
// lisr channel interfaces
// Request, response and register write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface lisr_req_if;
    logic                          valid;
    logic                          ready;
    logic                          req_type;
    logic [lisr_pkg::COORD_W-1:0]  coord_x;
    logic [lisr_pkg::COORD_W-1:0]  coord_y;
    logic [lisr_pkg::PIXEL_W-1:0]  load_pixel;

    modport source (output valid, req_type, coord_x, coord_y, load_pixel, input ready);
    modport sink   (input valid, req_type, coord_x, coord_y, load_pixel, output ready);
endinterface

interface lisr_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [lisr_pkg::PIXEL_W-1:0]  pixel_value;
    logic                          is_bezel;
    logic                          geometry_error;

    modport source (output valid, pixel_value, is_bezel, geometry_error, input ready);
    modport sink   (input valid, pixel_value, is_bezel, geometry_error, output ready);
endinterface

interface lisr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [lisr_pkg::CFG_IDX_W-1:0]  index;
    logic [lisr_pkg::CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/lisr_front.sv
// ----------------------------------------------------------------------------
// lisr_front
// Classifies requests: checks geometry, rotates and offsets fetch coordinates.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lisr_front #(
    parameter int MAX_VIEW_W = 256,
    parameter int MAX_VIEW_H = 256,
    parameter int MAX_PANEL  = 1024,
    parameter int MAX_SCALE  = 4
) (
    lisr_req_if.sink          req,
    input  lisr_pkg::cfg_t     cfg,
    input  logic               full,
    output logic               push,
    output lisr_pkg::q_entry_t entry
);
    import lisr_pkg::*;

    localparam int EXT_W = 14;

    logic [11:0]        span_w;
    logic [11:0]        span_h;
    logic [10:0]        lw;
    logic [10:0]        lh;
    logic [EXT_W-1:0]   reach_x;
    logic [EXT_W-1:0]   reach_y;
    logic               rot_ok;
    logic               geom_ok;
    logic [10:0]        px;
    logic [10:0]        py;
    logic [10:0]        lx;
    logic [10:0]        ly;
    logic [11:0]        dx;
    logic [11:0]        dy;
    logic               off_panel;
    logic               off_view;
    logic               is_load;
    logic               load_in_range;

    // geometry check
    always_comb
    begin
        span_w  = 12'(cfg.view_width) * 12'(cfg.scale);
        span_h  = 12'(cfg.view_height) * 12'(cfg.scale);
        lw      = (cfg.rotation == ROT_NONE) ? cfg.panel_width : cfg.panel_height;
        lh      = (cfg.rotation == ROT_NONE) ? cfg.panel_height : cfg.panel_width;
        reach_x = EXT_W'(cfg.offset_x) + EXT_W'(span_w);
        reach_y = EXT_W'(cfg.offset_y) + EXT_W'(span_h);
        rot_ok  = (cfg.rotation == ROT_NONE) || (cfg.rotation == ROT_CW)
               || (cfg.rotation == ROT_CCW);
        geom_ok = rot_ok
               && (cfg.panel_width != 11'd0)
               && (EXT_W'(cfg.panel_width) <= EXT_W'(MAX_PANEL))
               && (cfg.panel_height != 11'd0)
               && (EXT_W'(cfg.panel_height) <= EXT_W'(MAX_PANEL))
               && (cfg.view_width != 9'd0)
               && (EXT_W'(cfg.view_width) <= EXT_W'(MAX_VIEW_W))
               && (cfg.view_height != 9'd0)
               && (EXT_W'(cfg.view_height) <= EXT_W'(MAX_VIEW_H))
               && (cfg.scale != 3'd0)
               && (EXT_W'(cfg.scale) <= EXT_W'(MAX_SCALE))
               && (reach_x <= EXT_W'(lw))
               && (reach_y <= EXT_W'(lh));
    end

    // physical to logical, then remove the offset
    always_comb
    begin
        px        = {1'b0, req.coord_x};
        py        = {1'b0, req.coord_y};
        off_panel = (px >= cfg.panel_width) || (py >= cfg.panel_height);
        case (cfg.rotation)
            ROT_CW:
            begin
                lx = cfg.panel_height - 11'd1 - py;
                ly = px;
            end
            ROT_CCW:
            begin
                lx = py;
                ly = cfg.panel_width - 11'd1 - px;
            end
            default:
            begin
                lx = px;
                ly = py;
            end
        endcase
        dx       = {1'b0, lx} - 12'(cfg.offset_x);
        dy       = {1'b0, ly} - 12'(cfg.offset_y);
        off_view = dx[11] || dy[11]
                || ({1'b0, dx[10:0]} >= span_w) || ({1'b0, dy[10:0]} >= span_h);
    end

    always_comb
    begin
        is_load       = (req_type_t'(req.req_type) == REQ_LOAD);
        load_in_range = (EXT_W'(req.coord_x) < EXT_W'(MAX_VIEW_W))
                     && (EXT_W'(req.coord_y) < EXT_W'(MAX_VIEW_H));
        req.ready      = !full;
        // loads outside the store are dropped here
        push           = req.valid && !full && (!is_load || load_in_range);
        entry.is_load  = is_load;
        entry.geom_err = !is_load && !geom_ok;
        entry.bezel    = !is_load && geom_ok && (off_panel || off_view);
        entry.x        = is_load ? px : dx[10:0];
        entry.y        = is_load ? py : dy[10:0];
        entry.pixel    = req.load_pixel;
    end

endmodule

// File: sv/lisr_fifo.sv
// ----------------------------------------------------------------------------
// lisr_fifo
// Short queue between classification and the memory pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lisr_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  lisr_pkg::q_entry_t entry,
    output logic               full,
    input  logic               pop,
    output logic               head_valid,
    output lisr_pkg::q_entry_t head
);
    import lisr_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);

    q_entry_t         slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [PTR_W:0]   count_reg;
    logic [PTR_W:0]   count_next;

    always_comb
    begin
        full        = (count_reg == (PTR_W+1)'(QUEUE_DEPTH));
        head_valid  = (count_reg != '0);
        head        = slot_reg[rd_ptr_reg];
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= entry;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= (PTR_W+1)'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> (count_reg != '0))
        else $error("pop from empty queue");

endmodule

// File: sv/lisr_back.sv
// ----------------------------------------------------------------------------
// lisr_back
// Divides by the scale, forms the store address and runs the source memory.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module lisr_back #(
    parameter int MAX_VIEW_W = 256,
    parameter int MAX_VIEW_H = 256
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               head_valid,
    input  lisr_pkg::q_entry_t head,
    output logic               pop,
    input  logic [2:0]         scale,
    lisr_rsp_if.source         rsp
);
    import lisr_pkg::*;

    localparam int COL_W  = $clog2(MAX_VIEW_W);
    localparam int ROW_W  = $clog2(MAX_VIEW_H);
    localparam int DEPTH  = MAX_VIEW_W * MAX_VIEW_H;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PROD_W = LOGIC_W + RECIP_W;

    typedef struct packed {
        logic               is_load;
        logic               geom_err;
        logic               bezel;
        logic [COL_W-1:0]   col;
        logic [ROW_W-1:0]   row;
        logic [PIXEL_W-1:0] pixel;
    } idx_stage_t;

    typedef struct packed {
        logic               is_load;
        logic               geom_err;
        logic               bezel;
        logic [ADDR_W-1:0]  addr;
        logic [PIXEL_W-1:0] pixel;
    } addr_stage_t;

    logic [PIXEL_W-1:0] mem [DEPTH];

    logic               adv;
    logic [RECIP_W-1:0] recip;
    logic [PROD_W-1:0]  prod_x;
    logic [PROD_W-1:0]  prod_y;
    logic [LOGIC_W-1:0] qx;
    logic [LOGIC_W-1:0] qy;
    logic               mem_we;
    logic               mem_re;

    logic               s1_valid_reg;
    logic               s1_valid_next;
    idx_stage_t         s1_reg;
    idx_stage_t         s1_next;
    logic               s2_valid_reg;
    logic               s2_valid_next;
    addr_stage_t        s2_reg;
    addr_stage_t        s2_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    logic               out_err_reg;
    logic               out_bezel_reg;
    logic               out_mem_reg;
    logic [PIXEL_W-1:0] rdata_reg;

    // whole pipeline moves together whenever the output register can take
    always_comb
    begin
        adv = !out_valid_reg || rsp.ready;
        pop = adv && head_valid;
    end

    // divide by scale through the reciprocal
    always_comb
    begin
        recip            = recip_of(scale);
        prod_x           = PROD_W'(head.x) * PROD_W'(recip);
        prod_y           = PROD_W'(head.y) * PROD_W'(recip);
        qx               = prod_x[RECIP_SHIFT +: LOGIC_W];
        qy               = prod_y[RECIP_SHIFT +: LOGIC_W];
        s1_next.is_load  = head.is_load;
        s1_next.geom_err = head.geom_err;
        s1_next.bezel    = head.bezel;
        s1_next.col      = head.is_load ? head.x[COL_W-1:0] : qx[COL_W-1:0];
        s1_next.row      = head.is_load ? head.y[ROW_W-1:0] : qy[ROW_W-1:0];
        s1_next.pixel    = head.pixel;
        s1_valid_next    = adv ? head_valid : s1_valid_reg;
    end

    always_comb
    begin
        s2_next.is_load  = s1_reg.is_load;
        s2_next.geom_err = s1_reg.geom_err;
        s2_next.bezel    = s1_reg.bezel;
        s2_next.addr     = ADDR_W'(s1_reg.row) * ADDR_W'(MAX_VIEW_W) + ADDR_W'(s1_reg.col);
        s2_next.pixel    = s1_reg.pixel;
        s2_valid_next    = adv ? s1_valid_reg : s2_valid_reg;
    end

    always_comb
    begin
        mem_we         = adv && s2_valid_reg && s2_reg.is_load;
        mem_re         = adv && s2_valid_reg && !s2_reg.is_load
                      && !s2_reg.geom_err && !s2_reg.bezel;
        out_valid_next = adv ? (s2_valid_reg && !s2_reg.is_load) : out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            out_err_reg   <= s2_reg.geom_err;
            out_bezel_reg <= s2_reg.bezel;
            out_mem_reg   <= !s2_reg.geom_err && !s2_reg.bezel;
        end
    end

    // source frame, single port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[s2_reg.addr] <= s2_reg.pixel;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[s2_reg.addr];
        end
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.pixel_value    = out_mem_reg ? rdata_reg : '0;
    assign rsp.is_bezel       = out_bezel_reg;
    assign rsp.geometry_error = out_err_reg;

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(s1_reg) && $stable(s2_reg) && $stable(s2_valid_reg))
        else $error("pipeline moved during output stall");

    a_load_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (adv && s2_valid_reg && s2_reg.is_load) |=> !out_valid_reg)
        else $error("load produced a transaction");

    a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_err_reg) |-> (!out_bezel_reg && !out_mem_reg))
        else $error("error result carries bezel or pixel");

endmodule

// File: sv/letterbox_integer_scaler_rotate.sv
// ----------------------------------------------------------------------------
// letterbox_integer_scaler_rotate
// Integer nearest-neighbour upscaler with letterbox bezel and quarter turns.
// A fetch result is registered through the queue, stages s1 and s2 and the output register.
// Throughput: one request per cycle when not stalled, set by the single-port source memory.
// A four-entry queue keeps requests flowing while the response side stalls.
// Reset restores configuration defaults and empties queue and pipeline; the source frame is not cleared.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module letterbox_integer_scaler_rotate #(
    parameter int MAX_VIEW_W = 256,
    parameter int MAX_VIEW_H = 256,
    parameter int MAX_PANEL  = 1024,
    parameter int MAX_SCALE  = 4
) (
    input  logic        clk,
    input  logic        rst_n,
    lisr_req_if.sink    req,
    lisr_rsp_if.source  rsp,
    lisr_cfg_if.sink    cfg
);
    import lisr_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    logic     push;
    logic     full;
    logic     pop;
    logic     head_valid;
    q_entry_t entry;
    q_entry_t head;

    assign cfg.ready = 1'b1;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            unique case (cfg_idx_t'(cfg.index))
                CFG_ROTATION: cfg_next.rotation     = cfg.data[1:0];
                CFG_PANEL_W:  cfg_next.panel_width  = cfg.data[10:0];
                CFG_PANEL_H:  cfg_next.panel_height = cfg.data[10:0];
                CFG_VIEW_W:   cfg_next.view_width   = cfg.data[8:0];
                CFG_VIEW_H:   cfg_next.view_height  = cfg.data[8:0];
                CFG_OFFSET_X: cfg_next.offset_x     = cfg.data[9:0];
                CFG_OFFSET_Y: cfg_next.offset_y     = cfg.data[9:0];
                CFG_SCALE:    cfg_next.scale        = cfg.data[2:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.rotation     <= ROT_NONE;
            cfg_reg.panel_width  <= 11'd1024;
            cfg_reg.panel_height <= 11'd1024;
            cfg_reg.view_width   <= 9'd256;
            cfg_reg.view_height  <= 9'd256;
            cfg_reg.offset_x     <= 10'd0;
            cfg_reg.offset_y     <= 10'd0;
            cfg_reg.scale        <= 3'd1;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    lisr_front #(
        .MAX_VIEW_W (MAX_VIEW_W),
        .MAX_VIEW_H (MAX_VIEW_H),
        .MAX_PANEL  (MAX_PANEL),
        .MAX_SCALE  (MAX_SCALE)
    ) u_front (
        .req   (req),
        .cfg   (cfg_reg),
        .full  (full),
        .push  (push),
        .entry (entry)
    );

    lisr_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .entry      (entry),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head       (head)
    );

    lisr_back #(
        .MAX_VIEW_W (MAX_VIEW_W),
        .MAX_VIEW_H (MAX_VIEW_H)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop),
        .scale      (cfg_reg.scale),
        .rsp        (rsp)
    );

endmodule
